### design/yta_pkg.sv
package yta_pkg;

    localparam int CFG_W   = 12;
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 22;
    localparam int ARGB_W  = 32;
    localparam int SCALE_W = 19;
    localparam int MAG_W   = 18;
    localparam int SUM_W   = 11;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

    // register indexes of the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic signed [SCALE_W-1:0] COEF_RV = 19'sd1402;
    localparam logic signed [SCALE_W-1:0] COEF_BU = 19'sd1772;
    localparam logic signed [SCALE_W-1:0] COEF_GU = 19'sd344;
    localparam logic signed [SCALE_W-1:0] COEF_GV = 19'sd714;
    localparam logic [PIX_W:0]           CHROMA_OFFSET = 9'd128;

    localparam int              SCALE     = 1000;
    // floor(x / 1000) = (x * DIV_K) >> DIV_SHIFT, exact for x below 493447
    localparam logic [MAG_W-1:0] DIV_K     = 18'd134218;
    localparam int              DIV_SHIFT = 27;
    localparam logic [PIX_W-1:0] ALPHA     = 8'hFF;

    typedef struct packed {
        logic [IDX_W-1:0] dest;
        logic             last;
    } pos_t;

    function automatic logic [PIX_W-1:0] div_by_scale(input logic [MAG_W-1:0] x);
        logic [2*MAG_W-1:0] p;
        p = (2*MAG_W)'(x) * (2*MAG_W)'(DIV_K);
        return p[DIV_SHIFT+PIX_W-1:DIV_SHIFT];
    endfunction

    function automatic logic signed [PIX_W:0] floor_div_scale(
        input logic signed [SCALE_W-1:0] a
    );
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [PIX_W-1:0] q;
        neg = a[SCALE_W-1];
        if (neg)
        begin
            mag = MAG_W'(-a) + MAG_W'(SCALE - 1);
        end
        else
        begin
            mag = MAG_W'(a);
        end
        q = div_by_scale(mag);
        return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic logic signed [PIX_W:0] trunc_div_scale(
        input logic signed [SCALE_W-1:0] a
    );
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [PIX_W-1:0] q;
        neg = a[SCALE_W-1];
        mag = neg ? MAG_W'(-a) : MAG_W'(a);
        q = div_by_scale(mag);
        return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] x);
        logic [PIX_W-1:0] r;
        if (x < 0)
        begin
            r = '0;
        end
        else if (x > SUM_W'(255))
        begin
            r = 8'hFF;
        end
        else
        begin
            r = x[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/yta_position.sv
module yta_position
    import yta_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             step,
    output pos_t             pos
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (WW > CFG_W) ? WW : CFG_W;
    localparam int HCW = (HW > CFG_W) ? HW : CFG_W;
    localparam int PW  = CW + HW + 1;
    localparam int DW  = (PW > IDX_W) ? PW : IDX_W;

    logic [CFG_W-1:0] fw_reg;
    logic [CFG_W-1:0] fh_reg;
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;

    logic [CFG_W-1:0] fw_c;
    logic [CFG_W-1:0] fh_c;
    logic [WCW-1:0]   w_lim;
    logic [HCW-1:0]   h_lim;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic             outside;
    logic [WW:0]      col_p2;
    logic [HW:0]      row_p1;
    logic             col_wrap;
    logic             row_wrap;
    logic [DW-1:0]    dest_full;

    // a write takes effect in the same cycle it normalizes the counters against
    assign fw_c = (cfg_write && cfg_index == REG_WIDTH)  ? cfg_data : fw_reg;
    assign fh_c = (cfg_write && cfg_index == REG_HEIGHT) ? cfg_data : fh_reg;

    always_comb
    begin
        w_lim = WCW'(fw_c);
        if (w_lim < WCW'(2))
        begin
            w_lim = WCW'(2);
        end
        else if (w_lim > WCW'(MAX_WIDTH))
        begin
            w_lim = WCW'(MAX_WIDTH);
        end
        w_lim[0] = 1'b0;

        h_lim = HCW'(fh_c);
        if (h_lim < HCW'(1))
        begin
            h_lim = HCW'(1);
        end
        else if (h_lim > HCW'(MAX_HEIGHT))
        begin
            h_lim = HCW'(MAX_HEIGHT);
        end
    end

    assign w_eff = w_lim[WW-1:0];
    assign h_eff = h_lim[HW-1:0];

    assign outside  = (WW'(col_reg) >= w_eff) || (HW'(row_reg) >= h_eff);
    assign col_p2   = (WW+1)'(col_reg) + (WW+1)'(2);
    assign row_p1   = (HW+1)'(row_reg) + (HW+1)'(1);
    assign col_wrap = col_p2 >= (WW+1)'(w_eff);
    assign row_wrap = row_p1 >= (HW+1)'(h_eff);

    assign dest_full = DW'(col_reg) * DW'(h_eff) + DW'(h_eff) - DW'(1) - DW'(row_reg);

    assign pos.dest = dest_full[IDX_W-1:0];
    assign pos.last = col_wrap && row_wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= RESET_WIDTH;
            fh_reg  <= RESET_HEIGHT;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH:  fw_reg <= cfg_data;
                REG_HEIGHT: fh_reg <= cfg_data;
                default:    fw_reg <= fw_reg;
            endcase
            // restart the frame when the position falls outside the new size
            if (outside)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
        end
        else if (step)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_p1[RW-1:0];
            end
            else
            begin
                col_reg <= col_p2[CW-1:0];
            end
        end
    end

endmodule

### design/yta_convert.sv
module yta_convert
    import yta_pkg::*;
(
    input  logic [PIX_W-1:0]          luma_a,
    input  logic [PIX_W-1:0]          luma_b,
    input  logic signed [SCALE_W-1:0] scaled_r,
    input  logic signed [SCALE_W-1:0] scaled_b,
    input  logic signed [SCALE_W-1:0] scaled_g,
    output logic [ARGB_W-1:0]         argb_a,
    output logic [ARGB_W-1:0]         argb_b
);

    logic signed [PIX_W:0] q_r;
    logic signed [PIX_W:0] q_b;
    logic signed [PIX_W:0] q_g;
    logic signed [SUM_W-1:0] ya;
    logic signed [SUM_W-1:0] yb;

    // floor of the chroma offset equals truncation of the full sum once clamped
    assign q_r = floor_div_scale(scaled_r);
    assign q_b = floor_div_scale(scaled_b);
    assign q_g = trunc_div_scale(scaled_g);

    assign ya = $signed({3'b000, luma_a});
    assign yb = $signed({3'b000, luma_b});

    assign argb_a = {ALPHA,
                     clamp_byte(ya + SUM_W'(q_r)),
                     clamp_byte(ya - SUM_W'(q_g)),
                     clamp_byte(ya + SUM_W'(q_b))};

    assign argb_b = {ALPHA,
                     clamp_byte(yb + SUM_W'(q_r)),
                     clamp_byte(yb - SUM_W'(q_g)),
                     clamp_byte(yb + SUM_W'(q_b))};

endmodule

### design/yuv_to_argb_rotating.sv
// An accepted item is registered in stage one, then in the output registers.
// Throughput: one item per cycle while the output is not stalled; the position
// counters and the constant-coefficient conversion each complete within one stage.
// Reset clears both stage valids and the row and column counters, and sets
// the frame size to 640 x 480.
module yuv_to_argb_rotating
    import yta_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PIX_W-1:0]  luma_first,
    input  logic [PIX_W-1:0]  luma_second,
    input  logic [PIX_W-1:0]  chroma_v,
    input  logic [PIX_W-1:0]  chroma_u,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ARGB_W-1:0] pixel_first,
    output logic [ARGB_W-1:0] pixel_second,
    output logic [IDX_W-1:0]  dest_index,
    output logic              last_of_frame
);

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic [PIX_W-1:0]          s1_ya_reg;
    logic [PIX_W-1:0]          s1_yb_reg;
    logic signed [SCALE_W-1:0] s1_sr_reg;
    logic signed [SCALE_W-1:0] s1_sb_reg;
    logic signed [SCALE_W-1:0] s1_sg_reg;
    pos_t                      s1_pos_reg;

    logic [ARGB_W-1:0] pa_reg;
    logic [ARGB_W-1:0] pb_reg;
    logic [IDX_W-1:0]  dest_reg;
    logic              last_reg;

    logic s2_ready;
    logic s1_ready;
    logic accept;

    logic signed [PIX_W:0]     dv;
    logic signed [PIX_W:0]     du;
    logic signed [SCALE_W-1:0] sr;
    logic signed [SCALE_W-1:0] sb;
    logic signed [SCALE_W-1:0] sg;
    pos_t                      pos;
    logic [ARGB_W-1:0]         argb_a;
    logic [ARGB_W-1:0]         argb_b;

    assign s2_ready = !out_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign accept   = in_valid && s1_ready;
    assign in_stall = !s1_ready;

    assign dv = $signed({1'b0, chroma_v}) - $signed(CHROMA_OFFSET);
    assign du = $signed({1'b0, chroma_u}) - $signed(CHROMA_OFFSET);
    assign sr = COEF_RV * SCALE_W'(dv);
    assign sb = COEF_BU * SCALE_W'(du);
    assign sg = COEF_GU * SCALE_W'(du) + COEF_GV * SCALE_W'(dv);

    yta_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (accept),
        .pos       (pos)
    );

    yta_convert u_convert (
        .luma_a   (s1_ya_reg),
        .luma_b   (s1_yb_reg),
        .scaled_r (s1_sr_reg),
        .scaled_b (s1_sb_reg),
        .scaled_g (s1_sg_reg),
        .argb_a   (argb_a),
        .argb_b   (argb_b)
    );

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the item with its prescaled chroma terms and position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ya_reg  <= luma_first;
            s1_yb_reg  <= luma_second;
            s1_sr_reg  <= sr;
            s1_sb_reg  <= sb;
            s1_sg_reg  <= sg;
            s1_pos_reg <= pos;
        end
    end

    // hold the result while the output is stalled
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            pa_reg   <= argb_a;
            pb_reg   <= argb_b;
            dest_reg <= s1_pos_reg.dest;
            last_reg <= s1_pos_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_first   = pa_reg;
    assign pixel_second  = pb_reg;
    assign dest_index    = dest_reg;
    assign last_of_frame = last_reg;

endmodule

### verif/tb_top.sv
module tb_top
    import yta_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W = DEF_MAX_WIDTH;
    localparam int unsigned MAX_H = DEF_MAX_HEIGHT;

    typedef struct {
        logic [ARGB_W-1:0] first;
        logic [ARGB_W-1:0] second;
        logic [IDX_W-1:0]  dest;
        logic              last;
    } pixel_pair_t;

    class argb_rotation_board;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        int unsigned      row;
        int unsigned      col;
        pixel_pair_t      pending_pairs[$];
        int               errors;

        function new();
            errors = 0;
            width_reg = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            row = 0;
            col = 0;
        endfunction

        function int unsigned active_width();
            int unsigned w;
            w = width_reg;
            if (w < 2)
            begin
                w = 2;
            end
            if (w > MAX_W)
            begin
                w = MAX_W;
            end
            return w & ~32'd1;
        endfunction

        function int unsigned active_height();
            int unsigned h;
            h = height_reg;
            if (h < 1)
            begin
                h = 1;
            end
            if (h > MAX_H)
            begin
                h = MAX_H;
            end
            return h;
        endfunction

        // restart the frame when the counters fall outside the current size
        function void restart_if_outside();
            if (col >= active_width() || row >= active_height())
            begin
                row = 0;
                col = 0;
            end
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_WIDTH)
            begin
                width_reg = value;
            end
            else
            begin
                height_reg = value;
            end
            restart_if_outside();
        endfunction

        function logic [PIX_W-1:0] clamp_channel(int x);
            if (x < 0)
            begin
                return 8'h00;
            end
            if (x > 255)
            begin
                return 8'hFF;
            end
            return PIX_W'(x);
        endfunction

        function logic [PIX_W-1:0] scaled_channel(int y, int coef, int d);
            int total;
            total = SCALE * y + coef * d;
            if (total < 0)
            begin
                return 8'h00;
            end
            return clamp_channel(total / SCALE);
        endfunction

        function logic [ARGB_W-1:0] convert_pixel(logic [PIX_W-1:0] luma, int dv, int du,
                                                  int green_corr);
            int y;
            y = int'(luma);
            return {ALPHA, scaled_channel(y, int'(COEF_RV), dv),
                    clamp_channel(y - green_corr), scaled_channel(y, int'(COEF_BU), du)};
        endfunction

        function void note_pair(logic [PIX_W-1:0] y1, logic [PIX_W-1:0] y2,
                                logic [PIX_W-1:0] v, logic [PIX_W-1:0] u);
            int          dv;
            int          du;
            int          green_corr;
            int unsigned w;
            int unsigned h;
            pixel_pair_t p;
            dv = int'(v) - int'(CHROMA_OFFSET);
            du = int'(u) - int'(CHROMA_OFFSET);
            green_corr = (int'(COEF_GU) * du + int'(COEF_GV) * dv) / SCALE;
            restart_if_outside();
            w = active_width();
            h = active_height();
            p.first = convert_pixel(y1, dv, du, green_corr);
            p.second = convert_pixel(y2, dv, du, green_corr);
            p.dest = IDX_W'((h - 1 - row) + col * h);
            p.last = (col + 2 >= w) && (row + 1 >= h);
            pending_pairs.push_back(p);
            col += 2;
            if (col >= w)
            begin
                col = 0;
                row++;
                if (row >= h)
                begin
                    row = 0;
                end
            end
        endfunction

        function int pending();
            return pending_pairs.size();
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_pair(logic [ARGB_W-1:0] pf, logic [ARGB_W-1:0] ps,
                        logic [IDX_W-1:0] di, logic last);
            pixel_pair_t want;
            if (pending_pairs.size() == 0)
            begin
                report("result with no item pending");
                return;
            end
            want = pending_pairs.pop_front();
            if (pf !== want.first)
            begin
                report($sformatf("pixel_first %h, want %h", pf, want.first));
            end
            if (ps !== want.second)
            begin
                report($sformatf("pixel_second %h, want %h", ps, want.second));
            end
            if (di !== want.dest)
            begin
                report($sformatf("dest_index %0d, want %0d", di, want.dest));
            end
            if (last !== want.last)
            begin
                report($sformatf("last_of_frame %b, want %b", last, want.last));
            end
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic              cfg_index = REG_WIDTH;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [PIX_W-1:0]  luma_first = '0;
    logic [PIX_W-1:0]  luma_second = '0;
    logic [PIX_W-1:0]  chroma_v = '0;
    logic [PIX_W-1:0]  chroma_u = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ARGB_W-1:0] pixel_first;
    logic [ARGB_W-1:0] pixel_second;
    logic [IDX_W-1:0]  dest_index;
    logic              last_of_frame;

    int send_idle_pct = 12;
    int recv_stall_pct = 74;

    argb_rotation_board board = new();

    yuv_to_argb_rotating dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .luma_first    (luma_first),
        .luma_second   (luma_second),
        .chroma_v      (chroma_v),
        .chroma_u      (chroma_u),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_first   (pixel_first),
        .pixel_second  (pixel_second),
        .dest_index    (dest_index),
        .last_of_frame (last_of_frame)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // sample at the falling edge: everything is stable until the next rising edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                board.note_pair(luma_first, luma_second, chroma_v, chroma_u);
            end
            if (out_valid && !out_stall)
            begin
                board.check_pair(pixel_first, pixel_second, dest_index, last_of_frame);
            end
        end
    end

    function automatic logic [PIX_W-1:0] random_byte();
        if ($urandom_range(7) == 0)
        begin
            return $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return PIX_W'($urandom_range(255));
    endfunction

    // called at a rising edge; returns at the edge that accepts the item
    task automatic send_pair(input logic [PIX_W-1:0] y1, input logic [PIX_W-1:0] y2,
                             input logic [PIX_W-1:0] v, input logic [PIX_W-1:0] u);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        luma_first <= y1;
        luma_second <= y2;
        chroma_v <= v;
        chroma_u <= u;
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic send_random(input int n);
        repeat (n)
        begin
            send_pair(random_byte(), random_byte(), random_byte(), random_byte());
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic reconfigure(input int unsigned w, input int unsigned h,
                               input bit set_w, input bit set_h);
        wait_idle();
        if (set_w)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_WIDTH;
            cfg_data <= CFG_W'(w);
            @(posedge clk);
            board.write_reg(REG_WIDTH, CFG_W'(w));
        end
        if (set_h)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_HEIGHT;
            cfg_data <= CFG_W'(h);
            @(posedge clk);
            board.write_reg(REG_HEIGHT, CFG_W'(h));
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes and saturation corners at the reset frame size
        send_pair(8'd0, 8'd0, 8'd0, 8'd0);
        send_pair(8'd255, 8'd255, 8'd255, 8'd255);
        send_pair(8'd0, 8'd255, 8'd128, 8'd128);
        send_pair(8'd255, 8'd0, 8'd128, 8'd128);
        send_pair(8'd128, 8'd128, 8'd0, 8'd0);
        send_pair(8'd128, 8'd128, 8'd255, 8'd255);
        send_pair(8'd128, 8'd128, 8'd0, 8'd255);
        send_pair(8'd128, 8'd128, 8'd255, 8'd0);
        send_pair(8'd1, 8'd254, 8'd127, 8'd129);
        send_pair(8'd16, 8'd235, 8'd128, 8'd0);
        send_pair(8'd235, 8'd16, 8'd0, 8'd128);
        send_pair(8'd100, 8'd200, 8'd170, 8'd90);
        send_pair(8'd0, 8'd0, 8'd255, 8'd0);
        send_pair(8'd255, 8'd255, 8'd0, 8'd255);
        send_random(20);

        // smallest frame: every item ends a frame
        reconfigure(2, 1, 1, 1);
        send_random(20);
        // below range on both registers
        reconfigure(0, 0, 1, 1);
        send_random(10);
        // above range on both registers
        reconfigure(4095, 4095, 1, 1);
        send_random(40);
        // shrink the width mid-frame: column falls outside
        reconfigure(7, 0, 1, 0);
        send_random(30);

        send_idle_pct = 74;
        recv_stall_pct = 12;
        // shrink the height mid-frame: row falls outside
        reconfigure(0, 3, 0, 1);
        send_random(40);
        reconfigure(2048, 2048, 1, 1);
        send_random(40);
        reconfigure(1, 5, 1, 1);
        send_random(30);
        // widen mid-frame: position stays valid
        reconfigure(10, 0, 1, 0);
        send_random(30);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        reconfigure(12, 2, 1, 1);
        send_random(60);
        reconfigure(2049, 2047, 1, 1);
        send_random(30);
        for (int k = 0; k < 4; k++)
        begin
            reconfigure($urandom_range(16, 2), $urandom_range(6, 1), 1, 1);
            send_random(25);
        end

        wait_idle();
        if (board.errors == 0)
        begin
            $display("PASS yuv_to_argb_rotating");
        end
        else
        begin
            $display("FAIL yuv_to_argb_rotating");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL yuv_to_argb_rotating");
        $finish;
    end

endmodule

### files.f
design/yta_pkg.sv
design/yta_position.sv
design/yta_convert.sv
design/yuv_to_argb_rotating.sv
verif/tb_top.sv
